// ----- hw/rtl/first_fit_block_allocator_macros.svh -----
// Assertion macros shared by the allocator RTL.
// Needs no other file; the bodies are empty when SYNTHESIS is defined.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FFBA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("allocator assertion failed");
`define FFBA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("allocator assertion failed");
`else
`define FFBA_ASSERT(label, clk, rst_n, prop)
`define FFBA_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- hw/rtl/ffba_pkg.sv -----
// Shared constants and types for the first-fit block allocator.
// Has no dependencies; ffba_scan and the top-level allocator use it by scoped names.
package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 16;
    localparam int ADDR_BITS    = 32;
    localparam int DATA_W       = 32;
    localparam int HANDLE_W     = 7;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;

    localparam logic [DATA_W-1:0] ADDR_MASK =
        (ADDR_BITS >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((64'd1 << ADDR_BITS) - 64'd1);

    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_LIMIT = 1'b1;

    typedef struct packed {
        logic             clear;
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             flag;
    } scan_ctl_t;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  best;
        logic [DATA_W-1:0] best_addr;
    } scan_sts_t;

endpackage

// ----- hw/rtl/ffba_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module ffba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/ffba_scan.sv -----
// Newest-fit tracker: compares one table entry per valid cycle.
// Depends on ffba_pkg.
module ffba_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffba_pkg::scan_ctl_t           ctl,
    input  logic [ffba_pkg::DATA_W-1:0]   req_size,
    input  logic [ffba_pkg::DATA_W-1:0]   event_count,
    input  logic [ffba_pkg::DATA_W-1:0]   entry_addr,
    input  logic [ffba_pkg::DATA_W-1:0]   entry_size,
    input  logic [ffba_pkg::DATA_W-1:0]   entry_stamp,
    output ffba_pkg::scan_sts_t           sts
);

    logic                          found_reg, found_next;
    logic [ffba_pkg::IDX_W-1:0]    best_reg, best_next;
    logic [ffba_pkg::DATA_W-1:0]   addr_reg, addr_next;
    logic [ffba_pkg::DATA_W-1:0]   age_reg, age_next;
    logic [ffba_pkg::DATA_W-1:0]   age;
    logic                          take;

    always_comb
    begin
        age  = event_count - entry_stamp;
        take = ctl.valid && ctl.flag && (entry_size >= req_size)
               && (!found_reg || (age < age_reg));
        found_next = found_reg;
        best_next  = best_reg;
        addr_next  = addr_reg;
        age_next   = age_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next = 1'b1;
            best_next  = ctl.idx;
            addr_next  = entry_addr;
            age_next   = age;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        addr_reg <= addr_next;
        age_reg  <= age_next;
    end

    assign sts.found     = found_reg;
    assign sts.best      = best_reg;
    assign sts.best_addr = addr_reg;

endmodule

// ----- hw/rtl/first_fit_block_allocator.sv -----
// Block allocator: reuses the most recently freed block that fits, else carves a new block.
// A free request or a zero-size allocation goes through S_RESP into the output register.
// An allocation with a nonzero size walks the block table one entry per cycle through the
// table memories' single read ports, then goes through S_DECIDE and S_RESP into the output
// register. A response that the receiver stalls holds the next one back for as long as the
// stall lasts. Requests are taken one at a time, and a new request is accepted while the
// previous response still waits in the output register. Configuration writes go to heap_base
// at byte address 0 and heap_limit at byte address 4; the table memories need no clearing
// after reset. Depends on ffba_pkg, ffba_ram, ffba_scan and the macro header.
`include "first_fit_block_allocator_macros.svh"
module first_fit_block_allocator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [ffba_pkg::DATA_W-1:0]      pwdata,
    output logic [ffba_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic                             func,
    input  logic [ffba_pkg::DATA_W-1:0]      req_size,
    input  logic [ffba_pkg::HANDLE_W-1:0]    free_handle,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic                             ok,
    output logic [ffba_pkg::IDX_W-1:0]       given_handle,
    output logic [ffba_pkg::DATA_W-1:0]      payload_addr,
    output logic                             was_reused
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_RESP   = 2'd3;

    localparam int DW  = ffba_pkg::DATA_W;
    localparam int IW  = ffba_pkg::IDX_W;
    localparam int CW  = ffba_pkg::CNT_W;

    logic [1:0]           state_reg, state_next;
    logic [DW-1:0]        size_reg, size_next;
    logic [CW-1:0]        ptr_reg, ptr_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [IW-1:0]        rd_idx_reg, rd_idx_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [DW-1:0]        bump_reg, bump_next;
    logic [DW-1:0]        ctr_reg, ctr_next;
    logic [DW-1:0]        base_reg, base_next;
    logic [DW-1:0]        limit_reg, limit_next;
    logic [ffba_pkg::MAX_BLOCKS-1:0] flags_reg, flags_next;
    logic                 res_ok_reg, res_ok_next;
    logic [IW-1:0]        res_handle_reg, res_handle_next;
    logic [DW-1:0]        res_addr_reg, res_addr_next;
    logic                 res_reused_reg, res_reused_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic                 out_ok_reg, out_ok_next;
    logic [IW-1:0]        out_handle_reg, out_handle_next;
    logic [DW-1:0]        out_addr_reg, out_addr_next;
    logic                 out_reused_reg, out_reused_next;

    logic                 accept;
    logic                 cfg_write;
    logic                 issue;
    logic [DW+1:0]        carve_end;
    logic                 carve_ok;
    logic [DW-1:0]        carve_addr;
    logic                 blk_we;
    logic                 stamp_we;
    logic [IW-1:0]        stamp_waddr;
    logic [2*DW-1:0]      blk_rdata;
    logic [DW-1:0]        stamp_rdata;
    ffba_pkg::scan_ctl_t  scan_ctl;
    ffba_pkg::scan_sts_t  scan_sts;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == ffba_pkg::REG_HEAP_LIMIT) ? limit_reg : base_reg;
    assign issue     = (state_reg == S_SCAN) && (ptr_reg < count_reg);

    assign carve_end  = {2'b00, bump_reg} + (DW+2)'(ffba_pkg::HEADER_BYTES)
                        + {2'b00, size_reg};
    assign carve_ok   = (count_reg < CW'(ffba_pkg::MAX_BLOCKS))
                        && (carve_end <= {2'b00, limit_reg});
    assign carve_addr = (base_reg + bump_reg + DW'(ffba_pkg::HEADER_BYTES))
                        & ffba_pkg::ADDR_MASK;

    always_comb
    begin
        state_next      = state_reg;
        size_next       = size_reg;
        ptr_next        = ptr_reg;
        rd_vld_next     = issue;
        rd_idx_next     = ptr_reg[IW-1:0];
        count_next      = count_reg;
        bump_next       = bump_reg;
        ctr_next        = ctr_reg;
        base_next       = base_reg;
        limit_next      = limit_reg;
        flags_next      = flags_reg;
        res_ok_next     = res_ok_reg;
        res_handle_next = res_handle_reg;
        res_addr_next   = res_addr_reg;
        res_reused_next = res_reused_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        out_ok_next     = out_ok_reg;
        out_handle_next = out_handle_reg;
        out_addr_next   = out_addr_reg;
        out_reused_next = out_reused_reg;
        blk_we          = 1'b0;
        stamp_we        = 1'b0;
        stamp_waddr     = free_handle[IW-1:0];
        scan_ctl.clear  = 1'b0;
        scan_ctl.valid  = rd_vld_reg;
        scan_ctl.idx    = rd_idx_reg;
        scan_ctl.flag   = flags_reg[rd_idx_reg];

        if (cfg_write)
        begin
            if (paddr[2] == ffba_pkg::REG_HEAP_LIMIT)
            begin
                limit_next = pwdata;
            end
            else
            begin
                base_next = pwdata;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_ok_next     = 1'b0;
                    res_handle_next = '0;
                    res_addr_next   = '0;
                    res_reused_next = 1'b0;
                    size_next       = req_size;
                    ptr_next        = '0;
                    if (func)
                    begin
                        res_ok_next = 1'b1;
                        if (free_handle < CW'(count_reg))
                        begin
                            flags_next[free_handle[IW-1:0]] = 1'b1;
                            stamp_we = 1'b1;
                            ctr_next = ctr_reg + DW'(1);
                        end
                        state_next = S_RESP;
                    end
                    else if (req_size == '0)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        scan_ctl.clear = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
                else if (!rd_vld_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (scan_sts.found)
                begin
                    flags_next[scan_sts.best] = 1'b0;
                    res_ok_next     = 1'b1;
                    res_handle_next = scan_sts.best;
                    res_addr_next   = scan_sts.best_addr;
                    res_reused_next = 1'b1;
                end
                else if (carve_ok)
                begin
                    blk_we          = 1'b1;
                    count_next      = count_reg + CW'(1);
                    bump_next       = carve_end[DW-1:0];
                    res_ok_next     = 1'b1;
                    res_handle_next = count_reg[IW-1:0];
                    res_addr_next   = carve_addr;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    out_ok_next     = res_ok_reg;
                    out_handle_next = res_handle_reg;
                    out_addr_next   = res_addr_reg;
                    out_reused_next = res_reused_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            count_reg     <= '0;
            bump_reg      <= '0;
            ctr_reg       <= '0;
            base_reg      <= '0;
            limit_reg     <= {DW{1'b1}};
            flags_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            rd_vld_reg    <= rd_vld_next;
            count_reg     <= count_next;
            bump_reg      <= bump_next;
            ctr_reg       <= ctr_next;
            base_reg      <= base_next;
            limit_reg     <= limit_next;
            flags_reg     <= flags_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg       <= size_next;
        rd_idx_reg     <= rd_idx_next;
        res_ok_reg     <= res_ok_next;
        res_handle_reg <= res_handle_next;
        res_addr_reg   <= res_addr_next;
        res_reused_reg <= res_reused_next;
        out_ok_reg     <= out_ok_next;
        out_handle_reg <= out_handle_next;
        out_addr_reg   <= out_addr_next;
        out_reused_reg <= out_reused_next;
    end

    ffba_ram #(
        .WIDTH (2*DW),
        .DEPTH (ffba_pkg::MAX_BLOCKS)
    ) u_block_ram (
        .clk   (clk),
        .we    (blk_we),
        .waddr (count_reg[IW-1:0]),
        .wdata ({carve_addr, size_reg}),
        .raddr (ptr_reg[IW-1:0]),
        .rdata (blk_rdata)
    );

    ffba_ram #(
        .WIDTH (DW),
        .DEPTH (ffba_pkg::MAX_BLOCKS)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (stamp_waddr),
        .wdata (ctr_reg),
        .raddr (ptr_reg[IW-1:0]),
        .rdata (stamp_rdata)
    );

    ffba_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan_ctl),
        .req_size    (size_reg),
        .event_count (ctr_reg),
        .entry_addr  (blk_rdata[2*DW-1:DW]),
        .entry_size  (blk_rdata[DW-1:0]),
        .entry_stamp (stamp_rdata),
        .sts         (scan_sts)
    );

    assign rsp_valid    = rsp_valid_reg;
    assign ok           = out_ok_reg;
    assign given_handle = out_handle_reg;
    assign payload_addr = out_addr_reg;
    assign was_reused   = out_reused_reg;

    `FFBA_ASSERT_ALWAYS(a_pready_high, clk, pready)
    `FFBA_ASSERT(a_count_bounded, clk, rst_n, count_reg <= CW'(ffba_pkg::MAX_BLOCKS))
    `FFBA_ASSERT(a_no_write_in_scan, clk, rst_n, (state_reg == S_SCAN) |-> !blk_we && !stamp_we)
    `FFBA_ASSERT(a_read_within_table, clk, rst_n, rd_vld_reg |-> (CW'(rd_idx_reg) < count_reg))
    `FFBA_ASSERT(a_rsp_from_resp_state, clk, rst_n, $rose(rsp_valid_reg) |-> ($past(state_reg) == S_RESP))

endmodule
